// File: hw/rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes and defaults of the ADSR envelope applier.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int COUNT_BITS_DEF   = 24;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int STAGE_W   = 2;
  localparam int CHAN_CFG_W = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [16:0] UNITY = 17'd32768;

  typedef logic [STAGE_W-1:0] stage_t;

  localparam stage_t STAGE_ATTACK  = 2'd0;
  localparam stage_t STAGE_DECAY   = 2'd1;
  localparam stage_t STAGE_SUSTAIN = 2'd2;
  localparam stage_t STAGE_RELEASE = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ATTACK  = 3'd0;
  localparam cfg_idx_t CFG_DECAY   = 3'd1;
  localparam cfg_idx_t CFG_RELEASE = 3'd2;
  localparam cfg_idx_t CFG_SUSTAIN = 3'd3;
  localparam cfg_idx_t CFG_FRAMES  = 3'd4;
  localparam cfg_idx_t CFG_CHANS   = 3'd5;

endpackage

// File: hw/rtl/adsr_envelope_applier_unit.sv
// ----------------------------------------------------------------------------
// adsr_envelope_applier_unit
// Applies a linear ADSR gain in Q1.15 to interleaved 16-bit samples. Phase
// lengths are latched (and scaled to fit the sound) at each sound start; the
// gain divisions run on a bit-serial shift-add multiplier and a restoring
// divider that retires one quotient bit per cycle.
//
// Channel  Direction  Beat content
// in_      slave      tdata[15:0] sample_in
// out_     master     tdata[15:0] sample_out, tdata[31:16] gain,
//                     tuser[1:0] stage, tlast last_of_sound
// cfg_     slave      cfg_index register number, cfg_data register value
//
// Each beat passes gain select, apply and emit; in attack the serial divide
// comes between gain select and apply, and in decay or an unfinished release
// the serial multiply and then the 16-bit serial divide.
// The first beat of a sound first latches each phase length in turn, through
// the multiply and a COUNT_BITS-wide divide when the lengths must be scaled.
// One beat in flight; a new beat is taken while the last result waits.
// Reset is synchronous, active low; it restores the register defaults.
// ----------------------------------------------------------------------------
module adsr_envelope_applier_unit
  import adsr_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int CDW = (COUNT_BITS > 16) ? COUNT_BITS : 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,    // [15:0] sample_in
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,   // [15:0] sample_out, [31:16] gain
  output logic [1:0]          out_tuser,   // [1:0] stage
  output logic                out_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CDW-1:0]      cfg_data
);

  localparam int W    = COUNT_BITS;
  localparam int MW   = (W > 17) ? W : 17;
  localparam int PW   = 2 * MW;
  localparam int QW   = (W > 16) ? W : 16;
  localparam int RW   = W + 2;
  localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNTW = $clog2(MW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LSET  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DSET  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_GSEL  = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [W-1:0]          attack_r, attack_nxt;
  logic [W-1:0]          decay_r, decay_nxt;
  logic [W-1:0]          release_r, release_nxt;
  logic [15:0]           sustain_r, sustain_nxt;
  logic [W-1:0]          frames_r, frames_nxt;
  logic [CHAN_CFG_W-1:0] chans_r, chans_nxt;
  logic [W-1:0]          frame_idx_r, frame_idx_nxt;
  logic [CW-1:0]         chan_idx_r, chan_idx_nxt;
  logic [W-1:0]          eff_a_r, eff_a_nxt;
  logic [W-1:0]          eff_d_r, eff_d_nxt;
  logic [W-1:0]          eff_r_r, eff_r_nxt;
  logic                  lengths_ready_r, lengths_ready_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  mode_lat_r, mode_lat_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;

  logic signed [15:0]    x_r, x_nxt;
  logic [MW-1:0]         mcand_r, mcand_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [RW-1:0]         div_r, div_nxt;
  logic [QW-1:0]         dlo_r, dlo_nxt;
  logic [QW-1:0]         quo_r, quo_nxt;
  logic [GAIN_W-1:0]     gain_r, gain_nxt;
  stage_t                stage_r, stage_nxt;
  logic [15:0]           smp_r, smp_nxt;
  logic [15:0]           out_smp_r, out_smp_nxt;
  logic [GAIN_W-1:0]     out_gain_r, out_gain_nxt;
  stage_t                out_stage_r, out_stage_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [W-1:0]          frames_eff;
  logic [4:0]            chans_eff;
  logic [16:0]           s_clamp;
  logic [RW-1:0]         len_sum;
  logic                  scale;
  logic [W-1:0]          len_sel;
  logic [W:0]            sus_start;
  logic [W-1:0]          rel_start;
  logic [W-1:0]          elapsed;
  logic [MW:0]           mul_tmp;
  logic [RW:0]           div_rs;
  logic                  div_ge;
  logic [CNTW-1:0]       div_last;
  logic                  last_chan;
  logic                  last_frame;
  logic signed [32:0]    apply_p;
  logic                  in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_gain_r, out_smp_r};
  assign out_tuser  = out_stage_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    frames_eff = (frames_r == '0) ? W'(1) : frames_r;
    if (chans_r == '0) begin
      chans_eff = 5'd1;
    end else if (5'(chans_r) > 5'(MAX_CHANNELS)) begin
      chans_eff = 5'(MAX_CHANNELS);
    end else begin
      chans_eff = 5'(chans_r);
    end
    s_clamp   = ({1'b0, sustain_r} > UNITY) ? UNITY : {1'b0, sustain_r};
    len_sum   = RW'(attack_r) + RW'(decay_r) + RW'(release_r);
    scale     = len_sum > RW'(frames_eff);
    case (idx_r)
      2'd0:    len_sel = attack_r;
      2'd1:    len_sel = decay_r;
      default: len_sel = release_r;
    endcase
    sus_start  = (W+1)'(eff_a_r) + (W+1)'(eff_d_r);
    rel_start  = (frames_eff > eff_r_r) ? frames_eff - eff_r_r : '0;
    elapsed    = frame_idx_r - rel_start;
    mul_tmp    = (MW+1)'(prod_r[PW-1:MW]) + (MW+1)'(prod_r[0] ? mcand_r : '0);
    div_rs     = {rem_r, dlo_r[QW-1]};
    div_ge     = div_rs >= {1'b0, div_r};
    div_last   = mode_lat_r ? CNTW'(W - 1) : CNTW'(15);
    last_chan  = (6'(chan_idx_r) + 6'd1) >= 6'(chans_eff);
    last_frame = ((W+1)'(frame_idx_r) + (W+1)'(1)) >= (W+1)'(frames_eff);
    apply_p    = x_r * $signed({1'b0, gain_r});
  end

  always_comb begin
    state_nxt         = state_r;
    attack_nxt        = attack_r;
    decay_nxt         = decay_r;
    release_nxt       = release_r;
    sustain_nxt       = sustain_r;
    frames_nxt        = frames_r;
    chans_nxt         = chans_r;
    frame_idx_nxt     = frame_idx_r;
    chan_idx_nxt      = chan_idx_r;
    eff_a_nxt         = eff_a_r;
    eff_d_nxt         = eff_d_r;
    eff_r_nxt         = eff_r_r;
    lengths_ready_nxt = lengths_ready_r;
    idx_nxt           = idx_r;
    mode_lat_nxt      = mode_lat_r;
    cnt_nxt           = cnt_r;
    out_tvalid_nxt    = out_tvalid_r && !out_tready;
    x_nxt             = x_r;
    mcand_nxt         = mcand_r;
    prod_nxt          = prod_r;
    rem_nxt           = rem_r;
    div_nxt           = div_r;
    dlo_nxt           = dlo_r;
    quo_nxt           = quo_r;
    gain_nxt          = gain_r;
    stage_nxt         = stage_r;
    smp_nxt           = smp_r;
    out_smp_nxt       = out_smp_r;
    out_gain_nxt      = out_gain_r;
    out_stage_nxt     = out_stage_r;
    out_last_nxt      = out_last_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTACK:  attack_nxt  = cfg_data[W-1:0];
        CFG_DECAY:   decay_nxt   = cfg_data[W-1:0];
        CFG_RELEASE: release_nxt = cfg_data[W-1:0];
        CFG_SUSTAIN: sustain_nxt = cfg_data[15:0];
        CFG_FRAMES:  frames_nxt  = cfg_data[W-1:0];
        CFG_CHANS:   chans_nxt   = cfg_data[CHAN_CFG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt = $signed(in_tdata);
          if (lengths_ready_r) begin
            state_nxt = S_GSEL;
          end else begin
            idx_nxt   = 2'd0;
            state_nxt = S_LSET;
          end
        end
      end
      S_LSET: begin
        if (scale) begin
          mcand_nxt    = MW'(len_sel);
          prod_nxt     = PW'(frames_eff);
          div_nxt      = len_sum;
          mode_lat_nxt = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_MUL;
        end else begin
          case (idx_r)
            2'd0:    eff_a_nxt = len_sel;
            2'd1:    eff_d_nxt = len_sel;
            default: eff_r_nxt = len_sel;
          endcase
          if (idx_r == 2'd2) begin
            lengths_ready_nxt = 1'b1;
            state_nxt         = S_GSEL;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_MUL: begin
        prod_nxt = {mul_tmp, prod_r[MW-1:1]};
        cnt_nxt  = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(MW - 1)) begin
          state_nxt = S_DSET;
        end
      end
      S_DSET: begin
        if (mode_lat_r) begin
          rem_nxt = RW'(prod_r >> W);
          dlo_nxt = QW'(prod_r[W-1:0]) << (QW - W);
        end else begin
          rem_nxt = RW'(prod_r >> 16);
          dlo_nxt = QW'(prod_r[15:0]) << (QW - 16);
        end
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? RW'(div_rs - {1'b0, div_r}) : RW'(div_rs);
        dlo_nxt = dlo_r << 1;
        quo_nxt = {quo_r[QW-2:0], div_ge};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == div_last) begin
          if (mode_lat_r) begin
            case (idx_r)
              2'd0:    eff_a_nxt = quo_nxt[W-1:0];
              2'd1:    eff_d_nxt = quo_nxt[W-1:0];
              default: eff_r_nxt = quo_nxt[W-1:0];
            endcase
            if (idx_r == 2'd2) begin
              lengths_ready_nxt = 1'b1;
              state_nxt         = S_GSEL;
            end else begin
              idx_nxt   = idx_r + 2'd1;
              state_nxt = S_LSET;
            end
          end else begin
            if (stage_r == STAGE_DECAY) begin
              gain_nxt = GAIN_W'(UNITY - 17'(quo_nxt[15:0]));
            end else begin
              gain_nxt = quo_nxt[15:0];
            end
            state_nxt = S_APPLY;
          end
        end
      end
      S_GSEL: begin
        mode_lat_nxt = 1'b0;
        cnt_nxt      = '0;
        if (frame_idx_r < eff_a_r) begin
          stage_nxt = STAGE_ATTACK;
          prod_nxt  = PW'({frame_idx_r, 15'd0});
          div_nxt   = RW'(eff_a_r);
          state_nxt = S_DSET;
        end else if ((W+1)'(frame_idx_r) < sus_start) begin
          stage_nxt = STAGE_DECAY;
          mcand_nxt = MW'(frame_idx_r - eff_a_r);
          prod_nxt  = PW'(UNITY - s_clamp);
          div_nxt   = RW'(eff_d_r);
          state_nxt = S_MUL;
        end else if (frame_idx_r < rel_start) begin
          stage_nxt = STAGE_SUSTAIN;
          gain_nxt  = s_clamp[15:0];
          state_nxt = S_APPLY;
        end else begin
          stage_nxt = STAGE_RELEASE;
          if (eff_r_r == '0 || elapsed >= eff_r_r) begin
            gain_nxt  = '0;
            state_nxt = S_APPLY;
          end else begin
            mcand_nxt = MW'(s_clamp);
            prod_nxt  = PW'(eff_r_r - elapsed);
            div_nxt   = RW'(eff_r_r);
            state_nxt = S_MUL;
          end
        end
      end
      S_APPLY: begin
        smp_nxt   = apply_p[30:15];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_smp_nxt    = smp_r;
          out_gain_nxt   = gain_r;
          out_stage_nxt  = stage_r;
          out_last_nxt   = last_chan && last_frame;
          if (last_chan) begin
            chan_idx_nxt = '0;
            if (last_frame) begin
              frame_idx_nxt     = '0;
              lengths_ready_nxt = 1'b0;
            end else begin
              frame_idx_nxt = frame_idx_r + W'(1);
            end
          end else begin
            chan_idx_nxt = chan_idx_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      attack_r        <= '0;
      decay_r         <= '0;
      release_r       <= '0;
      sustain_r       <= UNITY[15:0];
      frames_r        <= W'(1);
      chans_r         <= CHAN_CFG_W'(1);
      frame_idx_r     <= '0;
      chan_idx_r      <= '0;
      eff_a_r         <= '0;
      eff_d_r         <= '0;
      eff_r_r         <= '0;
      lengths_ready_r <= 1'b0;
      idx_r           <= '0;
      mode_lat_r      <= 1'b0;
      cnt_r           <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      attack_r        <= attack_nxt;
      decay_r         <= decay_nxt;
      release_r       <= release_nxt;
      sustain_r       <= sustain_nxt;
      frames_r        <= frames_nxt;
      chans_r         <= chans_nxt;
      frame_idx_r     <= frame_idx_nxt;
      chan_idx_r      <= chan_idx_nxt;
      eff_a_r         <= eff_a_nxt;
      eff_d_r         <= eff_d_nxt;
      eff_r_r         <= eff_r_nxt;
      lengths_ready_r <= lengths_ready_nxt;
      idx_r           <= idx_nxt;
      mode_lat_r      <= mode_lat_nxt;
      cnt_r           <= cnt_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    mcand_r     <= mcand_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    dlo_r       <= dlo_nxt;
    quo_r       <= quo_nxt;
    gain_r      <= gain_nxt;
    stage_r     <= stage_nxt;
    smp_r       <= smp_nxt;
    out_smp_r   <= out_smp_nxt;
    out_gain_r  <= out_gain_nxt;
    out_stage_r <= out_stage_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("divider remainder reached the divisor");

  a_emit_with_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> lengths_ready_r)
    else $error("result emitted before phase lengths were latched");

  a_gain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> ({1'b0, gain_r} <= UNITY))
    else $error("envelope gain above unity");

  a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (6'(chan_idx_r) < 6'(MAX_CHANNELS)))
    else $error("channel index past the channel limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer idle right after taking a beat");

endmodule

// File: dv/adsr_envelope_applier_unit_test.sv
// ----------------------------------------------------------------------------
// adsr_envelope_applier_unit_test
// Self-checking bench for the ADSR envelope applier. It streams interleaved
// samples through the block under random flow control and keeps its own
// envelope predictor. The predictor tracks frame and channel position, the
// lengths latched at each sound start and the live register values. Every
// output beat is compared field by field with the oldest predicted beat.
// Directed runs cover the power-up defaults, all four stages, length scaling
// and out-of-range counts. Random sounds follow, mostly whole and sometimes
// cut short.
// ----------------------------------------------------------------------------
module adsr_envelope_applier_unit_test;
  import adsr_pkg::*;

  localparam int CW = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_SPARE_HI = 3'd7;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]   gain;
    stage_t              stage;
    logic                last;
  } shaped_beat_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [15:0]     in_tdata = '0;    // [15:0] sample_in
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [31:0]     out_tdata;        // [15:0] sample_out, [31:16] gain
  logic [1:0]      out_tuser;        // [1:0] stage
  logic            out_tlast;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_idx_t        cfg_index = '0;
  logic [CW-1:0]   cfg_data = '0;

  logic [CW-1:0]   reg_attack = '0;
  logic [CW-1:0]   reg_decay = '0;
  logic [CW-1:0]   reg_release = '0;
  logic [CW-1:0]   reg_frames = 1;
  logic [15:0]     reg_sustain = 16'd32768;
  logic [3:0]      reg_chans = 4'd1;
  logic [CW-1:0]   env_frame = '0;
  logic [3:0]      env_chan = '0;
  longint unsigned lat_attack = 0;
  longint unsigned lat_decay = 0;
  longint unsigned lat_release = 0;
  bit              lens_latched = 1'b0;

  shaped_beat_t    shaped_pending[$];
  int              mismatch_count = 0;
  int              in_idle_pct = 0;
  int              out_stall_pct = 0;
  int              cycle_count = 0;

  adsr_envelope_applier_unit dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("adsr_envelope_applier_unit: mismatch");
      $finish;
    end
  end

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    shaped_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (shaped_pending.size() == 0) begin
        flag_mismatch("unexpected beat, sample_out", '0, out_tdata[15:0]);
      end else begin
        want = shaped_pending.pop_front();
        if (out_tdata[15:0] !== want.sample)
          flag_mismatch("sample_out", want.sample, out_tdata[15:0]);
        if (out_tdata[31:16] !== want.gain)
          flag_mismatch("gain", want.gain, out_tdata[31:16]);
        if (out_tuser !== want.stage)
          flag_mismatch("stage", want.stage, out_tuser);
        if (out_tlast !== want.last)
          flag_mismatch("last_of_sound", want.last, out_tlast);
      end
    end
  end

  function automatic shaped_beat_t shape_sample(input logic [15:0] smp);
    longint unsigned frames, chans, sus, f, sus_start, rel_start, g, el, total;
    longint signed   prod;
    logic            last_chan, last_frame;
    shaped_beat_t    beat;
    frames = (reg_frames == 0) ? 1 : reg_frames;
    chans = (reg_chans == 0) ? 1 : reg_chans;
    if (chans > MAX_CHANNELS_DEF) chans = MAX_CHANNELS_DEF;
    sus = (reg_sustain > UNITY) ? UNITY : reg_sustain;
    f = env_frame;
    if (!lens_latched) begin
      total = reg_attack;
      total = total + reg_decay + reg_release;
      if (total > frames) begin
        lat_attack = reg_attack * frames / total;
        lat_decay = reg_decay * frames / total;
        lat_release = reg_release * frames / total;
      end else begin
        lat_attack = reg_attack;
        lat_decay = reg_decay;
        lat_release = reg_release;
      end
      lens_latched = 1'b1;
    end
    sus_start = lat_attack + lat_decay;
    rel_start = (frames > lat_release) ? frames - lat_release : 0;
    if (f < lat_attack) begin
      beat.stage = STAGE_ATTACK;
      g = f * UNITY / lat_attack;
    end else if (f < sus_start) begin
      beat.stage = STAGE_DECAY;
      g = UNITY - (f - lat_attack) * (UNITY - sus) / lat_decay;
    end else if (f < rel_start) begin
      beat.stage = STAGE_SUSTAIN;
      g = sus;
    end else begin
      beat.stage = STAGE_RELEASE;
      el = f - rel_start;
      if (lat_release == 0 || el >= lat_release) g = 0;
      else g = sus * (lat_release - el) / lat_release;
    end
    prod = longint'($signed(smp)) * longint'(g);
    beat.sample = 16'(prod >>> 15);
    beat.gain = g[15:0];
    last_chan = (env_chan + 1 >= chans);
    last_frame = (f + 1 >= frames);
    beat.last = last_chan && last_frame;
    if (last_chan) begin
      env_chan = '0;
      if (last_frame) begin
        env_frame = '0;
        lens_latched = 1'b0;
      end else begin
        env_frame = env_frame + 1'b1;
      end
    end else begin
      env_chan = env_chan + 1'b1;
    end
    return beat;
  endfunction

  task automatic send_sample(input logic [15:0] smp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    shaped_pending.push_back(shape_sample(smp));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ATTACK:  reg_attack = data;
      CFG_DECAY:   reg_decay = data;
      CFG_RELEASE: reg_release = data;
      CFG_SUSTAIN: reg_sustain = data[15:0];
      CFG_FRAMES:  reg_frames = data;
      CFG_CHANS:   reg_chans = data[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (shaped_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_power_up_defaults();
    send_sample(16'h7fff);
    send_sample(16'h8000);
    drain_results();
  endtask

  task automatic test_envelope_stages();
    write_reg(CFG_ATTACK, 2);
    write_reg(CFG_DECAY, 2);
    write_reg(CFG_RELEASE, 2);
    write_reg(CFG_SUSTAIN, 16384);
    write_reg(CFG_FRAMES, 8);
    write_reg(CFG_CHANS, 1);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h4000);
    send_sample(16'hffff);
    send_sample(16'h7fff);
    drain_results();
  endtask

  task automatic test_length_scaling();
    write_reg(CFG_ATTACK, COUNT_MAX);
    write_reg(CFG_DECAY, COUNT_MAX);
    write_reg(CFG_RELEASE, COUNT_MAX);
    write_reg(CFG_SUSTAIN, 16'hffff);
    write_reg(CFG_FRAMES, 3);
    write_reg(CFG_CHANS, 2);
    repeat (3) begin
      send_sample(16'h8000);
      send_sample(16'h7fff);
    end
    drain_results();
  endtask

  task automatic test_count_limits();
    write_reg(CFG_ATTACK, 0);
    write_reg(CFG_DECAY, 0);
    write_reg(CFG_RELEASE, 0);
    write_reg(CFG_SUSTAIN, 0);
    write_reg(CFG_FRAMES, 0);
    write_reg(CFG_CHANS, 0);
    send_sample(16'h7fff);
    drain_results();
    write_reg(CFG_SUSTAIN, 32768);
    write_reg(CFG_FRAMES, 1);
    write_reg(CFG_CHANS, 15);
    write_reg(CFG_SPARE_LO, COUNT_MAX);
    write_reg(CFG_SPARE_HI, COUNT_MAX);
    for (int k = 0; k < 8; k++) send_sample(16'(k * 16'h2492) ^ 16'h8001);
    drain_results();
  endtask

  task automatic test_midsound_change();
    write_reg(CFG_ATTACK, 1);
    write_reg(CFG_DECAY, 1);
    write_reg(CFG_RELEASE, 1);
    write_reg(CFG_SUSTAIN, 20000);
    write_reg(CFG_FRAMES, 3);
    write_reg(CFG_CHANS, 3);
    repeat (4) send_sample(16'h7fff);
    drain_results();
    write_reg(CFG_ATTACK, 0);
    write_reg(CFG_FRAMES, 1);
    write_reg(CFG_CHANS, 1);
    send_sample(16'h8000);
    send_sample(16'h8000);
    drain_results();
  endtask

  task automatic test_random_sounds(input int n_items, input int idle_pct,
                                    input int stall_pct);
    int            sent;
    int            frames;
    int            chans;
    int            burst;
    logic [CW-1:0] span;
    sent = 0;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    while (sent < n_items) begin
      drain_results();
      case ($urandom_range(9))
        0:       span = '0;
        1:       span = COUNT_MAX;
        2:       span = CW'($urandom_range(25, 5000));
        default: span = CW'($urandom_range(1, 24));
      endcase
      write_reg(CFG_FRAMES, span);
      case ($urandom_range(3))
        0: begin
          write_reg(CFG_ATTACK, 0);
          write_reg(CFG_DECAY, 0);
          write_reg(CFG_RELEASE, 0);
        end
        1: begin
          write_reg(CFG_ATTACK, CW'($urandom_range(0, span)));
          write_reg(CFG_DECAY, CW'($urandom_range(0, span)));
          write_reg(CFG_RELEASE, CW'($urandom_range(0, span)));
        end
        2: begin
          write_reg(CFG_ATTACK, CW'($urandom));
          write_reg(CFG_DECAY, CW'($urandom));
          write_reg(CFG_RELEASE, CW'($urandom));
        end
        default: begin
          write_reg(CFG_ATTACK, CW'($urandom_range(0, span / 3)));
          write_reg(CFG_DECAY, CW'($urandom_range(0, span / 3)));
          write_reg(CFG_RELEASE, CW'($urandom_range(0, span / 3)));
        end
      endcase
      write_reg(CFG_SUSTAIN, ($urandom_range(4) == 0) ? CW'($urandom_range(0, 65535))
                                                      : CW'($urandom_range(0, 32768)));
      write_reg(CFG_CHANS, ($urandom_range(4) == 0) ? CW'($urandom_range(0, 15))
                                                    : CW'($urandom_range(1, 8)));
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, CW'($urandom));
      frames = (span == 0) ? 1 : span;
      chans = (reg_chans == 0) ? 1 : ((reg_chans > 8) ? 8 : reg_chans);
      if (frames <= 24 && $urandom_range(9) < 7) burst = frames * chans;
      else burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_sample(16'($urandom));
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_up_defaults();
    test_envelope_stages();
    test_length_scaling();
    test_count_limits();
    test_midsound_change();
    test_random_sounds(300, 31, 80);
    test_random_sounds(300, 80, 31);
    test_random_sounds(300, 0, 0);
    drain_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && shaped_pending.size() == 0) begin
      $display("adsr_envelope_applier_unit: match");
    end else begin
      $display("adsr_envelope_applier_unit: mismatch");
    end
    $finish;
  end

endmodule
